@@ hdl/tpmc_pkg.sv @@
// ----------------------------------------------------------------------------
// tpmc_pkg: shared types, constants and microcode for the three-pass cipher
// Holds the control word layout, the datapath status group and the
// read-only program that steps the modular exponentiation.
// ----------------------------------------------------------------------------
package tpmc_pkg;

  // Default operand width and register reset values
  localparam int MOD_BITS_DEFAULT = 31;
  localparam logic [63:0] MODULUS_RESET = 64'd2147483647;
  localparam logic [63:0] EXPONENT_RESET = 64'd1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS = 2'd0,
    REG_ENC_EXP = 2'd1,
    REG_DEC_EXP = 2'd2,
    REG_UNUSED  = 2'd3
  } cfg_reg_t;

  // Input op codes
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // Program counter
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Datapath operations
  typedef enum logic [3:0] {
    DP_NONE,
    DP_ACCEPT,
    DP_RED_INIT,
    DP_RED,
    DP_ACC_INIT,
    DP_SQ_INIT,
    DP_MUL,
    DP_BASE_INIT,
    DP_NEXT,
    DP_ZERO,
    DP_EMIT
  } dp_op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_IN,
    C_SMALL_M,
    C_LOOP,
    C_EBIT0,
    C_EMORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    step_t  target;
  } ctl_t;

  typedef struct packed {
    logic cnt_last;
    logic ecnt_last;
    logic ebit;
    logic m_small;
    logic out_busy;
  } status_t;

  // Program steps
  localparam step_t S_WAIT     = 4'd0;
  localparam step_t S_CHECK    = 4'd1;
  localparam step_t S_RED_INIT = 4'd2;
  localparam step_t S_RED      = 4'd3;
  localparam step_t S_ACC_INIT = 4'd4;
  localparam step_t S_SQ_INIT  = 4'd5;
  localparam step_t S_SQ       = 4'd6;
  localparam step_t S_TEST     = 4'd7;
  localparam step_t S_MB_INIT  = 4'd8;
  localparam step_t S_MB       = 4'd9;
  localparam step_t S_NEXT     = 4'd10;
  localparam step_t S_EMIT     = 4'd11;
  localparam step_t S_RETURN   = 4'd12;
  localparam step_t S_ZERO     = 4'd13;

  // Control store: one word per step
  function automatic ctl_t tpmc_rom(input step_t pc);
    ctl_t w;
    unique case (pc)
      S_WAIT:     w = '{op: DP_ACCEPT,    cond: C_NO_IN,    target: S_WAIT};
      S_CHECK:    w = '{op: DP_NONE,      cond: C_SMALL_M,  target: S_ZERO};
      S_RED_INIT: w = '{op: DP_RED_INIT,  cond: C_NONE,     target: S_WAIT};
      S_RED:      w = '{op: DP_RED,       cond: C_LOOP,     target: S_RED};
      S_ACC_INIT: w = '{op: DP_ACC_INIT,  cond: C_NONE,     target: S_WAIT};
      S_SQ_INIT:  w = '{op: DP_SQ_INIT,   cond: C_NONE,     target: S_WAIT};
      S_SQ:       w = '{op: DP_MUL,       cond: C_LOOP,     target: S_SQ};
      S_TEST:     w = '{op: DP_NONE,      cond: C_EBIT0,    target: S_NEXT};
      S_MB_INIT:  w = '{op: DP_BASE_INIT, cond: C_NONE,     target: S_WAIT};
      S_MB:       w = '{op: DP_MUL,       cond: C_LOOP,     target: S_MB};
      S_NEXT:     w = '{op: DP_NEXT,      cond: C_EMORE,    target: S_SQ_INIT};
      S_EMIT:     w = '{op: DP_EMIT,      cond: C_OUT_BUSY, target: S_EMIT};
      S_RETURN:   w = '{op: DP_NONE,      cond: C_ALWAYS,   target: S_WAIT};
      S_ZERO:     w = '{op: DP_ZERO,      cond: C_ALWAYS,   target: S_EMIT};
      default:    w = '{op: DP_NONE,      cond: C_ALWAYS,   target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

@@ hdl/tpmc_if.sv @@
// ----------------------------------------------------------------------------
// tpmc_if: valid/ready channels of the three-pass cipher
// Request channel carries op and value; response channel carries result.
// ----------------------------------------------------------------------------
interface tpmc_req_if #(parameter int W = 31);
  logic         valid;
  logic         ready;
  logic         op;
  logic [W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

interface tpmc_rsp_if #(parameter int W = 31);
  logic         valid;
  logic         ready;
  logic [W-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface

@@ hdl/tpmc_datapath.sv @@
// ----------------------------------------------------------------------------
// tpmc_datapath: modular reduction and bit-serial modular multiply
// Executes one control word per cycle: restoring reduction of the input,
// shift-and-add modular multiply, exponent scan and the output register.
// ----------------------------------------------------------------------------
module tpmc_datapath #(
  parameter int MOD_BITS = tpmc_pkg::MOD_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  tpmc_pkg::ctl_t      ctl,
  input  logic                take,
  input  logic                in_op,
  input  logic [MOD_BITS-1:0] in_value,
  input  logic [MOD_BITS-1:0] modulus,
  input  logic [MOD_BITS-1:0] enc_exp,
  input  logic [MOD_BITS-1:0] dec_exp,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [MOD_BITS-1:0] result,
  output tpmc_pkg::status_t   status
);
  import tpmc_pkg::*;

  localparam int CNT_W = $clog2(MOD_BITS + 1);

  logic [MOD_BITS-1:0] val_sr;
  logic [MOD_BITS-1:0] expo;
  logic [MOD_BITS-1:0] base;
  logic [MOD_BITS-1:0] acc;
  logic [MOD_BITS-1:0] mul_a;
  logic [MOD_BITS-1:0] mul_b;
  logic [MOD_BITS-1:0] prod;
  logic [MOD_BITS-1:0] rem;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    ecnt;

  logic [MOD_BITS:0]   red_t;
  logic [MOD_BITS:0]   red_m;
  logic [MOD_BITS-1:0] rem_next;
  logic [MOD_BITS+1:0] mul_t;
  logic [MOD_BITS+1:0] m1;
  logic [MOD_BITS+1:0] m2;
  logic [MOD_BITS-1:0] prod_next;
  logic                out_busy;

  // Reduction step: shift in one value bit, subtract modulus once if needed
  always_comb begin
    red_t = {rem, val_sr[MOD_BITS-1]};
    red_m = {1'b0, modulus};
    if (red_t >= red_m) begin
      rem_next = MOD_BITS'(red_t - red_m);
    end else begin
      rem_next = red_t[MOD_BITS-1:0];
    end
  end

  // Multiply step: double, add operand on the multiplier bit, fold below modulus
  always_comb begin
    m1    = {2'b00, modulus};
    m2    = {1'b0, modulus, 1'b0};
    mul_t = {1'b0, prod, 1'b0} + (mul_b[MOD_BITS-1] ? {2'b00, mul_a} : '0);
    if (mul_t >= m2) begin
      prod_next = MOD_BITS'(mul_t - m2);
    end else if (mul_t >= m1) begin
      prod_next = MOD_BITS'(mul_t - m1);
    end else begin
      prod_next = mul_t[MOD_BITS-1:0];
    end
  end

  assign out_busy = out_valid && !out_ready;

  always_comb begin
    status.cnt_last  = (cnt == CNT_W'(1));
    status.ecnt_last = (ecnt == CNT_W'(1));
    status.ebit      = expo[MOD_BITS-1];
    status.m_small   = (modulus <= MOD_BITS'(1));
    status.out_busy  = out_busy;
  end

  // Output register: hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.op == DP_EMIT && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == DP_EMIT && !out_busy) begin
      result <= acc;
    end
  end

  // Working registers, one operation per control word
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      DP_ACCEPT: begin
        if (take) begin
          val_sr <= in_value;
          expo   <= (in_op == OP_DECRYPT) ? dec_exp : enc_exp;
        end
      end
      DP_RED_INIT: begin
        rem <= '0;
        cnt <= CNT_W'(MOD_BITS);
      end
      DP_RED: begin
        rem    <= rem_next;
        val_sr <= {val_sr[MOD_BITS-2:0], 1'b0};
        cnt    <= cnt - CNT_W'(1);
        if (status.cnt_last) begin
          base <= rem_next;
        end
      end
      DP_ACC_INIT: begin
        acc  <= MOD_BITS'(1);
        ecnt <= CNT_W'(MOD_BITS);
      end
      DP_SQ_INIT: begin
        mul_a <= acc;
        mul_b <= acc;
        prod  <= '0;
        cnt   <= CNT_W'(MOD_BITS);
      end
      DP_BASE_INIT: begin
        mul_a <= acc;
        mul_b <= base;
        prod  <= '0;
        cnt   <= CNT_W'(MOD_BITS);
      end
      DP_MUL: begin
        prod  <= prod_next;
        mul_b <= {mul_b[MOD_BITS-2:0], 1'b0};
        cnt   <= cnt - CNT_W'(1);
        if (status.cnt_last) begin
          acc <= prod_next;
        end
      end
      DP_NEXT: begin
        expo <= {expo[MOD_BITS-2:0], 1'b0};
        ecnt <= ecnt - CNT_W'(1);
      end
      DP_ZERO: begin
        acc <= '0;
      end
      DP_NONE, DP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/three_pass_modexp_cipher.sv @@
// Requests: a new request is taken only at the wait step, once the previous result
//   has entered the response register; a modulus of 0 or 1 skips straight to a zero
//   result. Otherwise the bit-serial modular multiplier, one multiplier bit per cycle
//   under microcode, sets the pace of each item.
// Reset (rst, synchronous): sequencer to the wait step, response invalid,
//   modulus to 2147483647 and both exponents to 1.
// ----------------------------------------------------------------------------
// three_pass_modexp_cipher: one party's step of the three-pass protocol
// Microcoded sequencer computing value^exponent mod modulus by
// square-and-multiply over a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
module three_pass_modexp_cipher #(
  parameter int MOD_BITS = tpmc_pkg::MOD_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tpmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [MOD_BITS-1:0]            cfg_data,
  tpmc_req_if.sink                       req,
  tpmc_rsp_if.source                     rsp
);
  import tpmc_pkg::*;

  logic [MOD_BITS-1:0] modulus;
  logic [MOD_BITS-1:0] enc_exp;
  logic [MOD_BITS-1:0] dec_exp;
  step_t               pc;
  step_t               pc_next;
  ctl_t                ctl;
  status_t             status;
  logic                jump;
  logic                take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_BITS'(MODULUS_RESET);
      enc_exp <= MOD_BITS'(EXPONENT_RESET);
      dec_exp <= MOD_BITS'(EXPONENT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODULUS: modulus <= cfg_data;
        REG_ENC_EXP: enc_exp <= cfg_data;
        REG_DEC_EXP: dec_exp <= cfg_data;
        REG_UNUSED: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Fetch control word and take requests only at the wait step
  assign ctl       = tpmc_rom(pc);
  assign req.ready = (ctl.op == DP_ACCEPT);
  assign take      = req.valid && req.ready;

  // Evaluate jump condition
  always_comb begin
    unique case (ctl.cond)
      C_NONE:     jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_IN:    jump = !req.valid;
      C_SMALL_M:  jump = status.m_small;
      C_LOOP:     jump = !status.cnt_last;
      C_EBIT0:    jump = !status.ebit;
      C_EMORE:    jump = !status.ecnt_last;
      C_OUT_BUSY: jump = status.out_busy;
      default:    jump = 1'b1;
    endcase
    pc_next = jump ? ctl.target : pc + step_t'(1);
  end

  // Advance step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  tpmc_datapath #(
    .MOD_BITS (MOD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .take      (take),
    .in_op     (req.op),
    .in_value  (req.value),
    .modulus   (modulus),
    .enc_exp   (enc_exp),
    .dec_exp   (dec_exp),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .result    (rsp.result),
    .status    (status)
  );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the three-pass modexp cipher step
// Drives op/value requests over the valid/ready channels and checks each
// response against an in-bench square-and-multiply model. It covers a set of
// directed settings (degenerate moduli, zero and all-ones exponents) and then
// random settings, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench;
  import tpmc_pkg::*;

  localparam int W              = MOD_BITS_DEFAULT;
  localparam int WATCHDOG_LIMIT = 25000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 2200;
  localparam int RANDOM_PHASES  = 9;
  localparam int PHASE_ITEMS    = 30;
  localparam logic [W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic         op;
    logic [W-1:0] value;
  } cipher_req_t;

  typedef struct {
    logic         op;
    logic [W-1:0] value;
    logic [W-1:0] power;
  } pending_power_t;

  // Predicts value^exponent mod modulus and checks responses in order
  class power_tracker;
    logic [W-1:0]   modulus;
    logic [W-1:0]   enc_exp;
    logic [W-1:0]   dec_exp;
    pending_power_t pending_powers[$];
    int             errors;
    int             requests;
    int             responses;

    function new();
      modulus  = MODULUS_RESET[W-1:0];
      enc_exp  = EXPONENT_RESET[W-1:0];
      dec_exp  = EXPONENT_RESET[W-1:0];
      errors   = 0;
      requests = 0;
      responses = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [W-1:0] data);
      case (idx)
        REG_MODULUS: modulus = data;
        REG_ENC_EXP: enc_exp = data;
        REG_DEC_EXP: dec_exp = data;
        default: ;
      endcase
    endfunction

    // Left-to-right square-and-multiply on wide intermediates
    function logic [W-1:0] raise_mod(logic [W-1:0] base, logic [W-1:0] ex);
      logic [127:0] acc;
      logic [127:0] b;
      logic [127:0] m;
      if (modulus <= 1) return '0;
      m   = 128'(modulus);
      b   = 128'(base) % m;
      acc = 128'(1) % m;
      for (int i = W - 1; i >= 0; i--) begin
        acc = (acc * acc) % m;
        if (ex[i]) acc = (acc * b) % m;
      end
      return acc[W-1:0];
    endfunction

    function void note_request(logic op, logic [W-1:0] value);
      pending_power_t p;
      p.op    = op;
      p.value = value;
      p.power = raise_mod(value, (op == OP_DECRYPT) ? dec_exp : enc_exp);
      pending_powers.push_back(p);
      requests++;
    endfunction

    function void check_result(logic [W-1:0] result);
      pending_power_t p;
      responses++;
      if (pending_powers.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response: result=%0d", result);
        return;
      end
      p = pending_powers.pop_front();
      if (result !== p.power) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: op=%0d value=%0d modulus=%0d expected %0d got %0d",
                   p.op, p.value, modulus, p.power, result);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [W-1:0]         cfg_data;
  logic                 calm;
  int                   settings_loaded;
  power_tracker         board;

  tpmc_req_if #(.W(W)) req_ch ();
  tpmc_rsp_if #(.W(W)) rsp_ch ();

  three_pass_modexp_cipher #(.MOD_BITS(W)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: alternate ready and stall stretches of random length, or stay ready when calm
  initial begin
    int run_left;
    logic level;
    rsp_ch.ready <= 1'b0;
    run_left = 0;
    level = 1'b0;
    forever begin
      @(posedge clk);
      if (calm) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          level = ~level;
          run_left = level ? $urandom_range(1, 60) : $urandom_range(1, 60);
        end
        rsp_ch.ready <= level;
        run_left--;
      end
    end
  end

  // Monitor both channels on every edge
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) board.note_request(req_ch.op, req_ch.value);
      if (rsp_ch.valid && rsp_ch.ready) board.check_result(rsp_ch.result);
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("timeout after %0d cycles without a transfer", WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Write one register, then drop the enable
  task automatic write_reg(cfg_reg_t idx, logic [W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.set_register(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setting(logic [W-1:0] m, logic [W-1:0] e, logic [W-1:0] d);
    write_reg(REG_MODULUS, m);
    write_reg(REG_ENC_EXP, e);
    write_reg(REG_DEC_EXP, d);
    settings_loaded++;
  endtask

  // Send a batch in bursts with random gaps, then wait for all responses
  task automatic run_batch(cipher_req_t batch[$], logic quiet);
    int burst_left;
    int gap;
    calm <= quiet;
    burst_left = 0;
    foreach (batch[i]) begin
      if (burst_left == 0) begin
        burst_left = quiet ? batch.size() : $urandom_range(1, 8);
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
          req_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      req_ch.valid <= 1'b1;
      req_ch.op    <= batch[i].op;
      req_ch.value <= batch[i].value;
      do @(posedge clk); while (!req_ch.ready);
      burst_left--;
    end
    req_ch.valid <= 1'b0;
    // Let the monitor note the last transfer before polling the queue
    @(posedge clk);
    while (board.pending_powers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [W-1:0] pick_exponent();
    logic [W-1:0] e;
    e = W'($urandom);
    case ($urandom_range(0, 7))
      0: e = '0;
      1: e = ALL_ONES;
      2: e = W'($urandom_range(1, 16));
      default: ;
    endcase
    return e;
  endfunction

  function automatic logic [W-1:0] pick_modulus();
    logic [W-1:0] m;
    m = W'($urandom);
    case ($urandom_range(0, 9))
      0: m = ALL_ONES;
      1: m = W'($urandom_range(3, 255) | 1);
      2: m = W'($urandom_range(0, 2));
      3: m[0] = 1'b0;
      default: begin
        m[W-1] = 1'b1;
        m[0] = 1'b1;
      end
    endcase
    return m;
  endfunction

  // Bias values toward the modulus boundary and the field extremes
  function automatic logic [W-1:0] pick_value(logic [W-1:0] m);
    logic [W-1:0] v;
    v = W'($urandom);
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = ALL_ONES;
      2: v = m - W'(1);
      3: v = m;
      4: v = m + W'(1);
      5: if (m != 0) v = v % m;
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    cipher_req_t batch[$];
    logic [W-1:0] m;
    board = new();
    settings_loaded = 0;
    calm <= 1'b0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_MODULUS;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.op <= OP_ENCRYPT;
    req_ch.value <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: values zero and one, and values at and just below the modulus
    batch = '{'{OP_ENCRYPT, '0}, '{OP_ENCRYPT, W'(1)},
              '{OP_DECRYPT, ALL_ONES}, '{OP_DECRYPT, ALL_ONES - W'(1)}};
    run_batch(batch, 1'b1);

    // All-ones encrypt exponent, zero decrypt exponent (also with value zero)
    load_setting(ALL_ONES, ALL_ONES, '0);
    batch = '{'{OP_ENCRYPT, W'(2)}, '{OP_ENCRYPT, ALL_ONES - W'(1)},
              '{OP_DECRYPT, '0}, '{OP_DECRYPT, W'(12345)}};
    run_batch(batch, 1'b0);

    // Zero modulus, then modulus of one
    write_reg(REG_MODULUS, '0);
    batch = '{'{OP_ENCRYPT, W'(7)}, '{OP_DECRYPT, ALL_ONES}};
    run_batch(batch, 1'b0);
    write_reg(REG_MODULUS, W'(1));
    batch = '{'{OP_ENCRYPT, '0}, '{OP_DECRYPT, W'(5)}};
    run_batch(batch, 1'b0);

    // Smallest odd prime with values around it
    load_setting(W'(3), W'(1), ALL_ONES);
    batch = '{'{OP_ENCRYPT, ALL_ONES}, '{OP_ENCRYPT, W'(2)}, '{OP_DECRYPT, W'(2)},
              '{OP_DECRYPT, W'(3)}, '{OP_DECRYPT, W'(4)}};
    run_batch(batch, 1'b1);

    // Even, non-prime modulus
    load_setting(W'(1000), W'(3), W'(341));
    batch = '{'{OP_ENCRYPT, W'(999)}, '{OP_DECRYPT, W'(1001)}, '{OP_ENCRYPT, ALL_ONES}};
    run_batch(batch, 1'b0);

    // Unused index must leave the setting alone
    write_reg(REG_UNUSED, W'($urandom));
    batch = '{'{OP_ENCRYPT, W'(5)}, '{OP_DECRYPT, W'(6)}};
    run_batch(batch, 1'b0);

    // Random settings with random traffic
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_setting(pick_modulus(), pick_exponent(), pick_exponent());
      m = board.modulus;
      batch = {};
      for (int k = 0; k < PHASE_ITEMS; k++)
        batch.push_back('{logic'($urandom_range(0, 1)), pick_value(m)});
      run_batch(batch, (ph % 3) == 2);
    end

    // Catch any stray response
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.pending_powers.size() != 0) board.errors++;

    $display("Summary: %0d requests, %0d responses across %0d register settings",
             board.requests, board.responses, settings_loaded);
    $display("  incl. zero/unit/even moduli, zero and all-ones exponents; %0d errors",
             board.errors);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
